[design/neural_field_integrate_centroid_macros.svh]
// Assertion macros shared by the neural field checker.
`ifndef NEURAL_FIELD_INTEGRATE_CENTROID_MACROS_SVH
`define NEURAL_FIELD_INTEGRATE_CENTROID_MACROS_SVH

// Clocked assertion, muted while reset is asserted.
`define NFIC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define NFIC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/nfic_pkg.sv]
// Shared types and constants for the neural field integrate/centroid block.
`timescale 1ns / 1ps

package nfic_pkg;

    localparam int POSITIONS = 256;
    localparam int POS_W     = $clog2(POSITIONS);
    localparam int HALF_POS  = POSITIONS / 2;

    localparam int ACT_W   = 32;
    localparam int GAIN_W  = 17;
    localparam int FRAC_W  = 16;
    localparam int DIFF_W  = ACT_W + 2;
    localparam int PROD_W  = DIFF_W + GAIN_W + 1;

    localparam int CNT_W   = $clog2(POSITIONS + 1);
    localparam int SUM_W   = $clog2(POSITIONS * (POSITIONS - 1) / 2 + 1);
    localparam int Q_W     = $clog2(3 * POSITIONS * POSITIONS + 1);
    localparam int CENT_SCALE_W = 7;
    localparam int DIVD_W  = Q_W + CENT_SCALE_W;
    localparam int DIV_CW  = $clog2(DIVD_W);
    localparam int CENT_W  = 18;

    localparam int OUT_POS_W    = 8;
    localparam int OUT_POS_LSB  = 0;
    localparam int OUT_ACT_LSB  = OUT_POS_LSB + OUT_POS_W;
    localparam int OUT_CENT_LSB = OUT_ACT_LSB + ACT_W;
    localparam int TDATA_W      = 64;
    localparam int PAD_W        = TDATA_W - OUT_CENT_LSB - CENT_W;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic signed [ACT_W-1:0]  ACT_RESET     = 32'hFFFB_0000;
    localparam logic [GAIN_W-1:0]        GAIN_RESET    = 17'd2621;
    localparam logic signed [ACT_W-1:0]  RESTING_RESET = 32'hFFFB_0000;
    localparam logic signed [ACT_W-1:0]  THRESH_RESET  = 32'd6554;
    localparam logic [CENT_W-1:0]        NO_CENTROID   = 18'h3FF00;
    localparam logic signed [PROD_W-1:0] ROUND_BIAS    = PROD_W'(32768);
    localparam logic [ACT_W-1:0]         SAT_POS       = 32'h7FFF_FFFF;
    localparam logic [ACT_W-1:0]         SAT_NEG       = 32'h8000_0000;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTING     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd2;

    typedef struct packed {
        logic [GAIN_W-1:0] step_gain;
        logic [ACT_W-1:0]  resting_level;
        logic [ACT_W-1:0]  active_threshold;
    } nfic_cfg_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [ACT_W-1:0] drive;
        logic             first;
        logic             last;
    } nfic_item_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_MUL,
        B_SUM,
        B_PREP,
        B_DIV,
        B_EMIT
    } nfic_bstate_t;

endpackage

[design/neural_field_integrate_centroid.sv]
// Top level of the neural field Euler update with active-region centroid.
//
//  channel  dir  handshake          payload (lsb first)
//  s_       in   s_tvalid/s_tready  tdata: drive[31:0]
//  m_       out  m_tvalid/m_tready  tdata: position, new_activation, peak_centroid; tlast
//  cfg_     in   cfg_wr_en          cfg_index, cfg_wr_data
//
//  Back unit works on one position at a time: store read, difference, multiply,
//  saturating update, result load. The last position of a frame with an active
//  position also runs the bit-serial centroid divider (one quotient bit per cycle).
//  A two-entry queue lets the front accept requests while the back works.
//  Reset is synchronous; the store reads as the reset level until written.
//  A stalled m_ side holds the result register and then backs up the queue.
`timescale 1ns / 1ps

module neural_field_integrate_centroid (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [nfic_pkg::ACT_W-1:0]        s_tdata,    // drive
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [nfic_pkg::TDATA_W-1:0]      m_tdata,    // position, new_activation, peak_centroid
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [nfic_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nfic_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import nfic_pkg::*;

    nfic_cfg_t  cfg_reg;
    nfic_item_t push_item, head_item;
    logic       q_push, q_pop, q_not_full, q_not_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_gain        <= GAIN_RESET;
            cfg_reg.resting_level    <= RESTING_RESET;
            cfg_reg.active_threshold <= THRESH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_STEP_GAIN: cfg_reg.step_gain        <= cfg_wr_data[GAIN_W-1:0];
                CFG_RESTING:   cfg_reg.resting_level    <= cfg_wr_data[ACT_W-1:0];
                CFG_THRESHOLD: cfg_reg.active_threshold <= cfg_wr_data[ACT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    nfic_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_not_full (q_not_full),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    nfic_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    nfic_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_item      (head_item),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

[design/nfic_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module nfic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/nfic_div.sv]
// Restoring divider, one quotient bit per cycle, for the frame centroid.
`timescale 1ns / 1ps

module nfic_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [nfic_pkg::DIVD_W-1:0] dividend,
    input  logic [nfic_pkg::CNT_W-1:0]  divisor,
    output logic                      done,
    output logic [nfic_pkg::DIVD_W-1:0] quotient
);
    import nfic_pkg::*;

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W:0]    shifted;
    logic              fits;

    always_comb begin
        shifted   = {rem_reg[CNT_W-1:0], quo_reg[DIVD_W-1]};
        fits      = shifted >= {1'b0, dvs_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            run_next = 1'b1;
            cnt_next = '0;
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end else if (run_reg) begin
            rem_next = fits ? (shifted - {1'b0, dvs_reg}) : shifted;
            quo_next = {quo_reg[DIVD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DIVD_W - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[design/nfic_fifo.sv]
// Short request queue between the front and back units.
`timescale 1ns / 1ps

module nfic_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  nfic_pkg::nfic_item_t push_item,
    output logic                 not_full,
    input  logic                 pop,
    output logic                 not_empty,
    output nfic_pkg::nfic_item_t head_item
);
    import nfic_pkg::*;

    nfic_item_t         entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign not_full  = count_reg != (FIFO_AW + 1)'(FIFO_DEPTH);
    assign not_empty = count_reg != '0;
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[design/nfic_front.sv]
// Front unit: accepts drive requests and tags them with position and frame marks.
`timescale 1ns / 1ps

module nfic_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [nfic_pkg::ACT_W-1:0]    s_tdata,
    input  logic                          q_not_full,
    output logic                          q_push,
    output nfic_pkg::nfic_item_t          q_item
);
    import nfic_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             is_last;

    assign s_tready = q_not_full;
    assign q_push   = s_tvalid && q_not_full;
    assign is_last  = pos_reg == POS_W'(POSITIONS - 1);

    always_comb begin
        q_item.pos   = pos_reg;
        q_item.drive = s_tdata;
        q_item.first = pos_reg == '0;
        q_item.last  = is_last;
        pos_next     = pos_reg;
        if (q_push) begin
            pos_next = is_last ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

[design/nfic_back.sv]
// Back unit: activation update, active-region tally, centroid and result register.
`timescale 1ns / 1ps

module nfic_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  nfic_pkg::nfic_cfg_t            cfg,
    input  logic                           q_not_empty,
    input  nfic_pkg::nfic_item_t           q_item,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [nfic_pkg::TDATA_W-1:0]   m_tdata,
    output logic                           m_tlast
);
    import nfic_pkg::*;

    nfic_bstate_t state_reg, state_next;

    nfic_item_t               work_reg;
    logic [POSITIONS-1:0]     valid_reg;
    logic                     hit_reg;
    logic [ACT_W-1:0]         a_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [ACT_W-1:0]         na_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  upper_reg;
    logic              first_active_reg;
    logic              wrap_reg;
    logic [CENT_W-1:0] held_reg;

    logic                  m_valid_reg;
    logic [OUT_POS_W-1:0]  m_pos_reg;
    logic [ACT_W-1:0]      m_act_reg;
    logic                  m_last_reg;
    logic [CENT_W-1:0]     m_cent_reg;

    logic             ram_re, ram_we, out_load, div_start, div_done;
    logic [ACT_W-1:0] ram_q;
    logic [DIVD_W-1:0] quotient;

    logic [ACT_W-1:0]         a_cur;
    logic signed [DIFF_W-1:0] diff_cur;
    logic signed [PROD_W-1:0] prod_cur;
    logic signed [PROD_W-1:0] rnd_sum, rnd, a_ext, full;
    logic [ACT_W-1:0]         na;
    logic                     active;
    logic [CNT_W-1:0]         count_new, upper_new;
    logic [SUM_W-1:0]         sum_new;
    logic [Q_W-1:0]           two_n_c, two_n_u, q_val;
    logic [DIVD_W-1:0]        dividend;

    nfic_ram #(
        .WIDTH (ACT_W),
        .DEPTH (POSITIONS)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (work_reg.pos),
        .wdata (na),
        .re    (ram_re),
        .raddr (q_item.pos),
        .rdata (ram_q)
    );

    nfic_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // update datapath
    always_comb begin
        a_cur    = hit_reg ? ram_q : ACT_RESET;
        diff_cur = $signed({{2{cfg.resting_level[ACT_W-1]}}, cfg.resting_level})
                 - $signed({{2{a_cur[ACT_W-1]}}, a_cur})
                 + $signed({{2{work_reg.drive[ACT_W-1]}}, work_reg.drive});
        prod_cur = $signed({1'b0, cfg.step_gain}) * diff_reg;
        rnd_sum  = prod_reg + ROUND_BIAS;
        rnd      = rnd_sum >>> FRAC_W;
        a_ext    = $signed({{(PROD_W - ACT_W){a_reg[ACT_W-1]}}, a_reg});
        full     = a_ext + rnd;
        if ((&full[PROD_W-1:ACT_W-1]) || !(|full[PROD_W-1:ACT_W-1])) begin
            na = full[ACT_W-1:0];
        end else begin
            na = full[PROD_W-1] ? SAT_NEG : SAT_POS;
        end
        active    = $signed(na) > $signed(cfg.active_threshold);
        count_new = (work_reg.first ? '0 : count_reg) + CNT_W'(active);
        sum_new   = (work_reg.first ? '0 : sum_reg)
                  + (active ? SUM_W'(work_reg.pos) : '0);
        upper_new = (work_reg.first ? '0 : upper_reg)
                  + CNT_W'(active && (work_reg.pos >= POS_W'(HALF_POS)));
    end

    // centroid numerator in half-position units
    always_comb begin
        two_n_c = Q_W'(count_reg) * Q_W'(2 * POSITIONS);
        two_n_u = Q_W'(upper_reg) * Q_W'(2 * POSITIONS);
        q_val   = Q_W'({sum_reg, 1'b0});
        if (wrap_reg) begin
            q_val = q_val + two_n_c - two_n_u;
            if (q_val >= two_n_c) begin
                q_val = q_val - two_n_c;
            end
        end
        dividend = {q_val, {CENT_SCALE_W{1'b0}}};
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (q_not_empty) begin
                    q_pop      = 1'b1;
                    ram_re     = 1'b1;
                    state_next = B_READ;
                end
            end
            B_READ: begin
                state_next = B_MUL;
            end
            B_MUL: begin
                state_next = B_SUM;
            end
            B_SUM: begin
                ram_we = 1'b1;
                if (work_reg.last && count_new != '0) begin
                    state_next = B_PREP;
                end else begin
                    state_next = B_EMIT;
                end
            end
            B_PREP: begin
                div_start  = 1'b1;
                state_next = B_DIV;
            end
            B_DIV: begin
                if (div_done) begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg        <= '0;
            count_reg        <= '0;
            sum_reg          <= '0;
            upper_reg        <= '0;
            first_active_reg <= 1'b0;
            wrap_reg         <= 1'b0;
            held_reg         <= NO_CENTROID;
            m_valid_reg      <= 1'b0;
        end else begin
            if (ram_we) begin
                valid_reg[work_reg.pos] <= 1'b1;
                count_reg <= count_new;
                sum_reg   <= sum_new;
                upper_reg <= upper_new;
                if (work_reg.first) begin
                    first_active_reg <= active;
                end
                if (work_reg.last) begin
                    wrap_reg <= first_active_reg || active;
                    if (count_new == '0) begin
                        held_reg <= NO_CENTROID;
                    end
                end
            end
            if (state_reg == B_DIV && div_done) begin
                held_reg <= CENT_W'(quotient);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            work_reg <= q_item;
            hit_reg  <= valid_reg[q_item.pos];
        end
        if (state_reg == B_READ) begin
            a_reg    <= a_cur;
            diff_reg <= diff_cur;
        end
        if (state_reg == B_MUL) begin
            prod_reg <= prod_cur;
        end
        if (ram_we) begin
            na_reg <= na;
        end
        if (out_load) begin
            m_pos_reg  <= OUT_POS_W'(work_reg.pos);
            m_act_reg  <= na_reg;
            m_last_reg <= work_reg.last;
            m_cent_reg <= held_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_cent_reg, m_act_reg, m_pos_reg};

endmodule

[design/nfic_checker.sv]
// Port-level checks for the neural field block, bound to the top level.
`timescale 1ns / 1ps
`include "neural_field_integrate_centroid_macros.svh"

module nfic_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [nfic_pkg::TDATA_W-1:0] m_tdata,
    input logic                         m_tlast
);
    import nfic_pkg::*;

    localparam logic [OUT_POS_W-1:0] LAST_POS = OUT_POS_W'(POSITIONS - 1);

    logic                 stalled;
    logic                 frame_end;
    logic [OUT_POS_W-1:0] out_pos;
    logic [CENT_W-1:0]    out_cent;
    logic                 last_ok;
    logic                 cent_ok;

    assign stalled   = m_tvalid && !m_tready;
    assign frame_end = m_tvalid && m_tlast;
    assign out_pos   = m_tdata[OUT_POS_LSB +: OUT_POS_W];
    assign out_cent  = m_tdata[OUT_CENT_LSB +: CENT_W];
    assign last_ok   = out_pos == LAST_POS;
    assign cent_ok   = !out_cent[CENT_W-1] || (out_cent == NO_CENTROID);

    `NFIC_ASSERT(a_hold_valid, aclk, aresetn, stalled |=> m_tvalid, "result dropped while stalled")
    `NFIC_ASSERT(a_hold_data, aclk, aresetn, stalled |=> $stable(m_tdata), "stall changed data")
    `NFIC_ASSERT(a_last_pos, aclk, aresetn, frame_end |-> last_ok, "tlast off last position")
    `NFIC_ASSERT(a_cent_range, aclk, aresetn, frame_end |-> cent_ok, "centroid out of range")
    `NFIC_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind neural_field_integrate_centroid nfic_checker u_nfic_checker (.*);

[tb/tb_neural_field_integrate_centroid.sv]
// Self-checking testbench for the neural field Euler update and centroid block.
`timescale 1ns / 1ps

module tb_neural_field_integrate_centroid;
    import nfic_pkg::*;

    localparam longint ACT_MAX = 64'sd2147483647;
    localparam longint ACT_MIN = -64'sd2147483648;
    localparam logic [ACT_W-1:0] DRIVE_MAX = 32'h7FFF_FFFF;
    localparam logic [ACT_W-1:0] DRIVE_MIN = 32'h8000_0000;

    typedef enum int {
        PLAN_NONE,
        PLAN_CLUSTER,
        PLAN_WRAP_LOW,
        PLAN_WRAP_HIGH,
        PLAN_WRAP_BOTH,
        PLAN_ALL,
        PLAN_SCATTER,
        PLAN_KINDS
    } plan_kind_t;

    typedef struct {
        logic [OUT_POS_W-1:0] position;
        logic [ACT_W-1:0]     activation;
        logic                 frame_done;
        logic [CENT_W-1:0]    centroid;
    } field_update_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [ACT_W-1:0]      s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int mismatch_count = 0;

    // predictor state
    logic [GAIN_W-1:0]        gain_reg;
    logic signed [ACT_W-1:0]  rest_level;
    logic signed [ACT_W-1:0]  thresh_reg;
    logic signed [ACT_W-1:0]  field_act [POSITIONS];
    int unsigned              field_pos;
    int unsigned              n_active;
    int unsigned              idx_sum;
    int unsigned              n_upper;
    bit                       first_on;
    logic [CENT_W-1:0]        cent_held;

    field_update_t            updates_due[$];
    bit [POSITIONS-1:0]       frame_plan = '0;

    neural_field_integrate_centroid dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver; a long hold-off is counted down here
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_updates
        field_update_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (updates_due.size() == 0) begin
                $error("result with no request pending: tdata=%h tlast=%b", m_tdata, m_tlast);
                mismatch_count++;
            end else begin
                want = updates_due.pop_front();
                if (m_tdata[OUT_POS_LSB +: OUT_POS_W] !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position,
                           m_tdata[OUT_POS_LSB +: OUT_POS_W]);
                    mismatch_count++;
                end
                if (m_tdata[OUT_ACT_LSB +: ACT_W] !== want.activation) begin
                    $error("new_activation: expected %0d, got %0d", $signed(want.activation),
                           $signed(m_tdata[OUT_ACT_LSB +: ACT_W]));
                    mismatch_count++;
                end
                if (m_tlast !== want.frame_done) begin
                    $error("frame_done: expected %0b, got %0b", want.frame_done, m_tlast);
                    mismatch_count++;
                end
                if (m_tdata[OUT_CENT_LSB +: CENT_W] !== want.centroid) begin
                    $error("peak_centroid: expected %0d, got %0d", $signed(want.centroid),
                           $signed(m_tdata[OUT_CENT_LSB +: CENT_W]));
                    mismatch_count++;
                end
            end
        end
    end

    function automatic void reset_field_model();
        gain_reg   = GAIN_RESET;
        rest_level = RESTING_RESET;
        thresh_reg = THRESH_RESET;
        foreach (field_act[i]) field_act[i] = ACT_RESET;
        field_pos  = 0;
        n_active   = 0;
        idx_sum    = 0;
        n_upper    = 0;
        first_on   = 1'b0;
        cent_held  = NO_CENTROID;
    endfunction

    task automatic integrate_position(input logic [ACT_W-1:0] drive);
        int unsigned   p;
        longint        cur;
        longint        diff;
        longint        prod;
        longint        nxt;
        longint        q;
        longint        span;
        longint        cent;
        bit            on;
        bit            done;
        field_update_t upd;
        p    = field_pos;
        cur  = longint'(field_act[p]);
        diff = longint'(rest_level) - cur + longint'($signed(drive));
        prod = longint'(gain_reg) * diff;
        nxt  = cur + ((prod + 64'sd32768) >>> 16);
        if (nxt > ACT_MAX) nxt = ACT_MAX;
        if (nxt < ACT_MIN) nxt = ACT_MIN;
        field_act[p] = nxt[ACT_W-1:0];
        on = nxt > longint'(thresh_reg);
        if (p == 0) begin
            n_active = 0;
            idx_sum  = 0;
            n_upper  = 0;
            first_on = on;
        end
        if (on) begin
            n_active++;
            idx_sum += p;
            if (2 * p >= POSITIONS) n_upper++;
        end
        done = (p == POSITIONS - 1);
        if (done) begin
            if (n_active == 0) begin
                cent_held = NO_CENTROID;
            end else begin
                span = 2 * longint'(POSITIONS) * longint'(n_active);
                q = 2 * longint'(idx_sum);
                // active region touching either end wraps around
                if (first_on || on) begin
                    q = q + span - 2 * longint'(POSITIONS) * longint'(n_upper);
                    if (q >= span) q -= span;
                end
                cent = (q * 128) / longint'(n_active);
                cent_held = cent[CENT_W-1:0];
            end
            n_active  = 0;
            idx_sum   = 0;
            n_upper   = 0;
            first_on  = 1'b0;
            field_pos = 0;
        end else begin
            field_pos = p + 1;
        end
        upd.position   = p[OUT_POS_W-1:0];
        upd.activation = nxt[ACT_W-1:0];
        upd.frame_done = done;
        upd.centroid   = cent_held;
        updates_due.push_back(upd);
    endtask

    // called at a falling edge; leaves tvalid high after the request is taken
    task automatic offer_drive(input logic [ACT_W-1:0] drive);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= drive;
        do @(posedge aclk); while (!s_tready);
        integrate_position(drive);
        @(negedge aclk);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (updates_due.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_STEP_GAIN: gain_reg   = data[GAIN_W-1:0];
            CFG_RESTING:   rest_level = data;
            CFG_THRESHOLD: thresh_reg = data;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] gain,
                            input logic [CFG_DATA_W-1:0] rest,
                            input logic [CFG_DATA_W-1:0] thr);
        write_reg(CFG_STEP_GAIN, gain);
        write_reg(CFG_RESTING, rest);
        write_reg(CFG_THRESHOLD, thr);
    endtask

    function automatic void plan_frame();
        plan_kind_t kind;
        int         lo;
        int         len;
        int         len2;
        kind = plan_kind_t'($urandom_range(PLAN_KINDS - 1));
        frame_plan = '0;
        case (kind)
            PLAN_NONE: ;
            PLAN_CLUSTER: begin
                len = $urandom_range(60, 1);
                lo  = $urandom_range(POSITIONS - 1 - len, 1);
                for (int i = 0; i < len; i++) frame_plan[lo + i] = 1'b1;
            end
            PLAN_WRAP_LOW: begin
                len = $urandom_range(40, 1);
                for (int i = 0; i < len; i++) frame_plan[i] = 1'b1;
            end
            PLAN_WRAP_HIGH: begin
                len = $urandom_range(40, 1);
                for (int i = 0; i < len; i++) frame_plan[POSITIONS - 1 - i] = 1'b1;
            end
            PLAN_WRAP_BOTH: begin
                len  = $urandom_range(30, 1);
                len2 = $urandom_range(30, 1);
                for (int i = 0; i < len; i++) frame_plan[i] = 1'b1;
                for (int i = 0; i < len2; i++) frame_plan[POSITIONS - 1 - i] = 1'b1;
            end
            PLAN_ALL: frame_plan = '1;
            default: begin
                for (int i = 0; i < POSITIONS; i++) frame_plan[i] = ($urandom_range(3) == 0);
            end
        endcase
    endfunction

    function automatic logic [ACT_W-1:0] pick_drive(input bit on);
        logic [ACT_W-1:0] mag;
        if ($urandom_range(9) == 0) return $urandom;
        mag = $urandom_range(32'h4000_0000, 32'h2000_0000);
        return on ? mag : -mag;
    endfunction

    task automatic run_frames(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            if (field_pos == 0) plan_frame();
            offer_drive(pick_drive(frame_plan[field_pos]));
        end
    endtask

    task automatic test_directed_extremes();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        offer_drive('0);
        offer_drive(DRIVE_MAX);
        offer_drive(DRIVE_MIN);
        offer_drive('1);
        offer_drive(32'd1);
        stop_sending();
        wait_drained();
        // unit gain, top resting level: positive saturation
        set_regs(32'h0001_0000, DRIVE_MAX, DRIVE_MIN);
        offer_drive(DRIVE_MAX);
        offer_drive(DRIVE_MIN);
        offer_drive('0);
        stop_sending();
        wait_drained();
        // zero gain holds the store
        set_regs('0, DRIVE_MIN, DRIVE_MAX);
        offer_drive(DRIVE_MAX);
        offer_drive(DRIVE_MIN);
        offer_drive(32'h5555_AAAA);
        stop_sending();
        wait_drained();
        // oversized gain, upper data bits dropped
        write_reg(CFG_STEP_GAIN, 32'hFFFF_FFFF);
        offer_drive(DRIVE_MIN);
        offer_drive(DRIVE_MAX);
        offer_drive(DRIVE_MIN);
        offer_drive(32'hAAAA_5555);
        stop_sending();
        wait_drained();
    endtask

    task automatic test_unity_gain_frames();
        set_regs(32'h0001_0000, '0, '0);
        send_idle_pct = 26;
        recv_idle_pct = 64;
        run_frames(290);
        stop_sending();
        wait_drained();
    endtask

    task automatic test_high_gain_frames();
        int rest;
        int thr;
        rest = int'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
        thr  = int'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
        set_regs($urandom_range(32'h0001_0000, 32'h0000_C000), rest, thr);
        send_idle_pct = 64;
        recv_idle_pct = 26;
        run_frames(290);
        stop_sending();
        wait_drained();
    endtask

    task automatic test_random_registers();
        set_regs($urandom, $urandom, $urandom);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_frames(240);
        stop_sending();
        wait_drained();
    endtask

    task automatic test_output_stall();
        set_regs(32'h0001_0000, '0, '0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge aclk);
        hold_left = 300;
        @(negedge aclk);
        run_frames(40);
        stop_sending();
        wait_drained();
        run_frames(20);
        stop_sending();
        wait_drained();
    endtask

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        reset_field_model();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_extremes();
        test_unity_gain_frames();
        test_high_gain_frames();
        test_random_registers();
        test_output_stall();
        wait_drained();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && updates_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[neural_field_integrate_centroid.f]
+incdir+design
design/nfic_pkg.sv
design/nfic_ram.sv
design/nfic_div.sv
design/nfic_fifo.sv
design/nfic_front.sv
design/nfic_back.sv
design/neural_field_integrate_centroid.sv
design/nfic_checker.sv
tb/tb_neural_field_integrate_centroid.sv
